### rtl/single_level_page_translate_macros.svh
// assertion macros for the page translation block
`ifndef SINGLE_LEVEL_PAGE_TRANSLATE_MACROS_SVH
`define SINGLE_LEVEL_PAGE_TRANSLATE_MACROS_SVH

// property that must hold whenever the block is out of reset
`define SLPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define SLPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/slpt_pkg.sv
// state type for the page translation block
package slpt_pkg;

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b000000000001,
        ST_IDLE   = 12'b000000000010,
        ST_LOOK   = 12'b000000000100,
        ST_DECIDE = 12'b000000001000,
        ST_RING1  = 12'b000000010000,
        ST_RING2  = 12'b000000100000,
        ST_RING3  = 12'b000001000000,
        ST_RING4  = 12'b000010000000,
        ST_RING5  = 12'b000100000000,
        ST_RING6  = 12'b001000000000,
        ST_EVICT  = 12'b010000000000,
        ST_OUT    = 12'b100000000000
    } t_state;

endpackage

### rtl/slpt_ring.sv
// frame ring memory: next and prev links with owner records
module slpt_ring #(
    parameter int unsigned FW    = 8,
    parameter int unsigned FRAMES = 256,
    parameter int unsigned OWN_W = 14
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [FW-1:0]    i_waddr,
    input  logic             i_wsel_next,
    input  logic [FW-1:0]    i_wdata,
    input  logic             i_owe,
    input  logic [OWN_W-1:0] i_odata,
    input  logic [FW-1:0]    i_raddr,
    output logic [FW-1:0]    o_next,
    output logic [FW-1:0]    o_prev,
    output logic [OWN_W-1:0] o_owner
);
    logic [FW-1:0]    r_next_mem [FRAMES];
    logic [FW-1:0]    r_prev_mem [FRAMES];
    logic [OWN_W-1:0] r_own_mem  [FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_we && i_wsel_next) begin
            r_next_mem[i_waddr] <= i_wdata;
        end
        if (i_we && !i_wsel_next) begin
            r_prev_mem[i_waddr] <= i_wdata;
        end
        if (i_owe) begin
            r_own_mem[i_waddr] <= i_odata;
        end
        o_next  <= r_next_mem[i_raddr];
        o_prev  <= r_prev_mem[i_raddr];
        o_owner <= r_own_mem[i_raddr];
    end
endmodule

### rtl/slpt_table.sv
// page table memory: valid bit and frame number per page
module slpt_table #(
    parameter int unsigned AW = 14,
    parameter int unsigned FW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [FW:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [FW:0]   o_rdata
);
    logic [FW:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/single_level_page_translate.sv
// Page translation with FIFO or LRU frame replacement. After reset a clearing
// pass writes every page table entry invalid and rebuilds the frame ring, while
// no item is accepted. An accepted item passes through the look and decide
// states, then the evict state on a miss or six single link writes that relink
// the ring on an LRU hit on any frame but the oldest, and ends in the output
// state. The result is loaded into the output register there; a result still
// waiting there holds the block in that state, and so holds off the next item.
module single_level_page_translate #(
    parameter int unsigned NUM_PROCS        = 4,
    parameter int unsigned VADDR_BITS       = 24,
    parameter int unsigned PAGE_OFFSET_BITS = 12,
    parameter int unsigned FRAMES           = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_proc_id,
    input  logic [23:0] i_vaddr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [7:0]  o_frame,
    output logic [19:0] o_phys_addr
);
`include "single_level_page_translate_macros.svh"

    localparam int unsigned PB   = VADDR_BITS - PAGE_OFFSET_BITS;
    localparam int unsigned PW   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int unsigned AW   = PW + PB;
    localparam int unsigned FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned OW   = PW + PB + 1;
    localparam int unsigned TSZ  = NUM_PROCS * (2**PB);
    localparam int unsigned CLRN = (TSZ > FRAMES) ? TSZ : FRAMES;
    localparam int unsigned CW   = $clog2(CLRN) + 1;

    slpt_pkg::t_state r_st, n_st;
    logic          r_mode;
    logic [CW-1:0] r_cnt;
    logic [FW-1:0] r_old;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_vic;
    logic [PAGE_OFFSET_BITS-1:0] r_off;
    logic [FW-1:0] r_f, r_fn, r_fp, r_op;
    logic          r_hit;

    logic [AW-1:0] idx_in;
    logic [PW-1:0] proc_in;
    logic [PB-1:0] page_in;
    logic [1:0]    proc_rem;

    // process number folded into range by compare and subtract
    always_comb begin
        proc_rem = i_proc_id;
        for (int k = 0; k < 3; k++) begin
            if (32'(proc_rem) >= NUM_PROCS) begin
                proc_rem = proc_rem - 2'(NUM_PROCS);
            end
        end
    end

    assign page_in = PB'(32'(i_vaddr) >> PAGE_OFFSET_BITS);
    assign proc_in = PW'(proc_rem);
    assign idx_in  = AW'({proc_in, page_in});

    // page table port
    logic          t_we;
    logic [AW-1:0] t_waddr, t_raddr;
    logic [FW:0]   t_wdata, t_rdata;
    // ring port
    logic          g_we, g_sel, g_owe;
    logic [FW-1:0] g_waddr, g_wdata, g_raddr, g_next, g_prev;
    logic [OW-1:0] g_odata, g_owner;

    slpt_table #(.AW(AW), .FW(FW)) u_table (
        .i_clk, .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    slpt_ring #(.FW(FW), .FRAMES(FRAMES), .OWN_W(OW)) u_ring (
        .i_clk, .i_we(g_we), .i_waddr(g_waddr), .i_wsel_next(g_sel),
        .i_wdata(g_wdata), .i_owe(g_owe), .i_odata(g_odata), .i_raddr(g_raddr),
        .o_next(g_next), .o_prev(g_prev), .o_owner(g_owner)
    );

    // owner record layout: used bit, proc, page
    logic          own_used;
    logic [AW-1:0] own_idx;
    assign own_used = g_owner[OW-1];
    assign own_idx  = g_owner[AW-1:0];

    logic [FW-1:0] cnt_f;
    assign cnt_f = FW'(r_cnt);

    assign o_ready = (r_st == slpt_pkg::ST_IDLE);

    // clearing pass writes two ring links per entry across two sub-phases
    logic r_cph;
    logic r_ev_clr;

    always_comb begin
        n_st    = r_st;
        t_we    = 1'b0;
        t_waddr = r_idx;
        t_wdata = '0;
        t_raddr = r_idx;
        g_we    = 1'b0;
        g_sel   = 1'b1;
        g_owe   = 1'b0;
        g_waddr = r_f;
        g_wdata = '0;
        g_odata = '0;
        g_raddr = r_old;
        case (r_st)
            slpt_pkg::ST_CLEAR: begin
                t_we    = (32'(r_cnt) < TSZ) && !r_cph;
                t_waddr = AW'(r_cnt);
                g_we    = (32'(r_cnt) < FRAMES);
                g_owe   = (32'(r_cnt) < FRAMES) && !r_cph;
                g_waddr = cnt_f;
                g_sel   = !r_cph;
                if (r_cph) begin
                    g_wdata = (cnt_f == '0) ? FW'(FRAMES - 1) : cnt_f - 1'b1;
                end else begin
                    g_wdata = (32'(r_cnt) == FRAMES - 1) ? '0 : cnt_f + 1'b1;
                end
                if (r_cph && 32'(r_cnt) == CLRN - 1) begin
                    n_st = slpt_pkg::ST_IDLE;
                end
            end
            slpt_pkg::ST_IDLE: begin
                t_raddr = idx_in;
                if (i_valid) begin
                    n_st = slpt_pkg::ST_LOOK;
                end
            end
            slpt_pkg::ST_LOOK: begin
                n_st = slpt_pkg::ST_DECIDE;
            end
            slpt_pkg::ST_DECIDE: begin
                // table data and oldest-frame ring data are valid here
                if (t_rdata[FW]) begin
                    if (!r_mode) begin
                        n_st = slpt_pkg::ST_OUT;
                    end else if (t_rdata[FW-1:0] == r_old) begin
                        n_st = slpt_pkg::ST_OUT;
                    end else begin
                        g_raddr = t_rdata[FW-1:0];
                        n_st    = slpt_pkg::ST_RING1;
                    end
                end else begin
                    t_we    = 1'b1;
                    t_wdata = {1'b1, r_old};
                    g_owe   = 1'b1;
                    g_waddr = r_old;
                    g_odata = {1'b1, r_idx};
                    n_st    = slpt_pkg::ST_EVICT;
                end
            end
            slpt_pkg::ST_EVICT: begin
                // drop the former owner's mapping of the evicted frame
                if (r_ev_clr) begin
                    t_we    = 1'b1;
                    t_waddr = r_vic;
                    t_wdata = '0;
                end
                n_st = slpt_pkg::ST_OUT;
            end
            slpt_pkg::ST_RING1: begin
                // next[prev[f]] = next[f], f's links arrive this cycle
                g_we = 1'b1; g_sel = 1'b1; g_waddr = g_prev; g_wdata = g_next;
                n_st = slpt_pkg::ST_RING2;
            end
            slpt_pkg::ST_RING2: begin
                // prev[next[f]] = prev[f]
                g_we = 1'b1; g_sel = 1'b0; g_waddr = r_fn; g_wdata = r_fp;
                n_st = slpt_pkg::ST_RING3;
            end
            slpt_pkg::ST_RING3: begin
                g_we = 1'b1; g_sel = 1'b1; g_waddr = r_f; g_wdata = r_old;
                n_st = slpt_pkg::ST_RING4;
            end
            slpt_pkg::ST_RING4: begin
                // prev[f] = prev[o] (r_op, fixed up if f sat right before o)
                g_we = 1'b1; g_sel = 1'b0; g_waddr = r_f; g_wdata = r_op;
                n_st = slpt_pkg::ST_RING5;
            end
            slpt_pkg::ST_RING5: begin
                g_we = 1'b1; g_sel = 1'b1; g_waddr = r_op; g_wdata = r_f;
                n_st = slpt_pkg::ST_RING6;
            end
            slpt_pkg::ST_RING6: begin
                g_we = 1'b1; g_sel = 1'b0; g_waddr = r_old; g_wdata = r_f;
                n_st = slpt_pkg::ST_OUT;
            end
            slpt_pkg::ST_OUT: begin
                if (!o_valid || i_ready) begin
                    n_st = slpt_pkg::ST_IDLE;
                end
            end
            default: n_st = slpt_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= slpt_pkg::ST_CLEAR;
            r_mode  <= 1'b0;
            r_cnt   <= '0;
            r_cph   <= 1'b0;
            r_old   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_st == slpt_pkg::ST_CLEAR) begin
                r_cph <= !r_cph;
                if (r_cph) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_st == slpt_pkg::ST_DECIDE) begin
                if (t_rdata[FW]) begin
                    r_hit <= 1'b1;
                    r_f   <= t_rdata[FW-1:0];
                    if (r_mode && t_rdata[FW-1:0] == r_old) begin
                        r_old <= g_next;
                    end
                end else begin
                    r_hit <= 1'b0;
                    r_f   <= r_old;
                    r_old <= g_next;
                end
                r_op     <= g_prev;
                r_vic    <= own_idx;
                r_ev_clr <= !t_rdata[FW] && own_used;
            end
            if (r_st == slpt_pkg::ST_RING1) begin
                // f's links arrived this cycle
                r_fn <= g_next;
                r_fp <= g_prev;
                if (g_next == r_old) begin
                    r_op <= g_prev;
                end
            end
            if (r_st == slpt_pkg::ST_OUT && (!o_valid || i_ready)) begin
                o_valid     <= 1'b1;
                o_hit       <= r_hit;
                o_frame     <= 8'(r_f);
                o_phys_addr <= 20'((32'(r_f) << PAGE_OFFSET_BITS) + 32'(r_off));
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (r_st == slpt_pkg::ST_IDLE && i_valid) begin
                r_idx <= idx_in;
                r_off <= PAGE_OFFSET_BITS'(i_vaddr);
            end
        end
    end

    `SLPT_ASSERT(a_ready_idle, !(o_ready && r_st != slpt_pkg::ST_IDLE), "ready outside idle")
    `SLPT_ASSERT_NEXT(a_out_after, (r_st == slpt_pkg::ST_OUT && !o_valid), o_valid, "result lost")
    `SLPT_ASSERT(a_onehot, $onehot(r_st), "state not one-hot")

endmodule

### tb/sv/tb_top.sv
// testbench for the page translation block with fifo and lru replacement
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned N_PROCS     = 4;
    localparam int unsigned PAGE_W      = 12;
    localparam int unsigned N_FRAMES    = 256;
    localparam int unsigned N_RANDOM    = 240;
    localparam int unsigned STALL_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 20;

    localparam bit MODE_FIFO = 1'b0;
    localparam bit MODE_LRU  = 1'b1;

    typedef struct packed {
        logic        hit;
        logic [7:0]  frame;
        logic [19:0] phys_addr;
    } t_xlate;

    typedef struct {
        logic [1:0]  proc_id;
        logic [23:0] vaddr;
        bit          known;
        t_xlate      res;
    } t_access;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_proc_id;
    logic [23:0] i_vaddr;
    logic        o_valid;
    logic        i_ready;
    logic        o_hit;
    logic [7:0]  o_frame;
    logic [19:0] o_phys_addr;

    single_level_page_translate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_proc_id   (i_proc_id),
        .i_vaddr     (i_vaddr),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_frame     (o_frame),
        .o_phys_addr (o_phys_addr)
    );

    // translation state mirrored from the block
    bit          mdl_valid [N_PROCS*(1<<PAGE_W)];
    logic [7:0]  mdl_frame [N_PROCS*(1<<PAGE_W)];
    bit          mdl_used  [N_FRAMES];
    logic [13:0] mdl_owner [N_FRAMES];
    logic [7:0]  mdl_next  [N_FRAMES];
    logic [7:0]  mdl_prev  [N_FRAMES];
    logic [7:0]  mdl_oldest;
    bit          mdl_mode;

    t_xlate xlate_q[$];
    int     fail_cnt;
    int     idle_cycles;
    bit     recv_lru_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void mirror_reset();
        for (int i = 0; i < N_PROCS*(1<<PAGE_W); i++) mdl_valid[i] = 1'b0;
        for (int i = 0; i < N_FRAMES; i++) begin
            mdl_used[i] = 1'b0;
            mdl_next[i] = 8'(i + 1);
            mdl_prev[i] = 8'(i - 1);
        end
        mdl_oldest = '0;
        mdl_mode   = MODE_FIFO;
    endfunction

    function automatic t_xlate translate(logic [1:0] pid, logic [23:0] va);
        logic [13:0] idx;
        logic [13:0] victim;
        logic [7:0]  f;
        logic [7:0]  o;
        t_xlate      r;
        idx = {pid, va[23:12]};
        if (mdl_valid[idx]) begin
            r.hit = 1'b1;
            f = mdl_frame[idx];
            if (mdl_mode == MODE_LRU) begin
                if (f == mdl_oldest) begin
                    mdl_oldest = mdl_next[mdl_oldest];
                end else begin
                    // unlink f and put it right before the oldest
                    o = mdl_oldest;
                    mdl_next[mdl_prev[f]] = mdl_next[f];
                    mdl_prev[mdl_next[f]] = mdl_prev[f];
                    mdl_next[f] = o;
                    mdl_prev[f] = mdl_prev[o];
                    mdl_next[mdl_prev[o]] = f;
                    mdl_prev[o] = f;
                end
            end
        end else begin
            r.hit = 1'b0;
            f = mdl_oldest;
            if (mdl_used[f]) begin
                victim = mdl_owner[f];
                mdl_valid[victim] = 1'b0;
            end
            mdl_frame[idx] = f;
            mdl_valid[idx] = 1'b1;
            mdl_used[f]    = 1'b1;
            mdl_owner[f]   = idx;
            mdl_oldest     = mdl_next[f];
        end
        r.frame     = f;
        r.phys_addr = {f, va[11:0]};
        return r;
    endfunction

    task automatic send_access(t_access a);
        t_xlate r;
        i_valid   <= 1'b1;
        i_proc_id <= a.proc_id;
        i_vaddr   <= a.vaddr;
        do @(posedge i_clk); while (!o_ready);
        r = translate(a.proc_id, a.vaddr);
        // typed rows are checked against their own expected value
        xlate_q.push_back(a.known ? a.res : r);
    endtask

    // bursts of back to back items with random gaps
    task automatic send_burst(ref t_access list[$]);
        int burst;
        burst = 0;
        foreach (list[k]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            send_access(list[k]);
            burst--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain_and_set_mode(bit mode);
        while (xlate_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_mode = mode;
    endtask

    function automatic t_access mk(logic [1:0] pid, logic [23:0] va);
        t_access a;
        a.proc_id = pid;
        a.vaddr   = va;
        a.known   = 1'b0;
        a.res     = '0;
        return a;
    endfunction

    function automatic t_access mk_known(logic [1:0] pid, logic [23:0] va, logic h,
                                         logic [7:0] f);
        t_access a;
        a = mk(pid, va);
        a.known = 1'b1;
        a.res   = '{hit: h, frame: f, phys_addr: {f, va[11:0]}};
        return a;
    endfunction

    // working set drawn from a small pool of pages so hits and evictions both occur
    function automatic t_access rand_access(int pool);
        logic [11:0] pg;
        if ($urandom_range(0, 9) == 0) pg = 12'($urandom);
        else pg = 12'($urandom_range(0, pool - 1)) ^ 12'hA50;
        return mk(2'($urandom), {pg, 12'($urandom)});
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_lru_hold) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_xlate want;
        if (i_rst_n && o_valid && i_ready) begin
            if (xlate_q.size() == 0) begin
                $error("result with nothing expected: hit %0d frame %0d", o_hit, o_frame);
                fail_cnt++;
            end else begin
                want = xlate_q.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, o_hit);
                    fail_cnt++;
                end
                if (o_frame !== want.frame) begin
                    $error("frame: expected %0d actual %0d", want.frame, o_frame);
                    fail_cnt++;
                end
                if (o_phys_addr !== want.phys_addr) begin
                    $error("phys_addr: expected %h actual %h", want.phys_addr, o_phys_addr);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog, also covers the clearing pass after reset
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_access list[$];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        i_valid       = 1'b0;
        i_proc_id     = '0;
        i_vaddr       = '0;
        fail_cnt      = 0;
        idle_cycles   = 0;
        recv_lru_hold = 1'b0;
        mirror_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fresh faults fill frames in order, repeat pages hit, extremes of fields
        list.push_back(mk_known(2'd0, 24'h000000, 1'b0, 8'd0));
        list.push_back(mk_known(2'd3, 24'hFFFFFF, 1'b0, 8'd1));
        list.push_back(mk_known(2'd0, 24'h000FFF, 1'b1, 8'd0));
        list.push_back(mk_known(2'd3, 24'hFFF000, 1'b1, 8'd1));
        list.push_back(mk_known(2'd1, 24'hFFF000, 1'b0, 8'd2));
        list.push_back(mk_known(2'd2, 24'h000555, 1'b0, 8'd3));
        list.push_back(mk_known(2'd1, 24'h555AAA, 1'b0, 8'd4));
        list.push_back(mk_known(2'd2, 24'hAAA555, 1'b0, 8'd5));
        send_burst(list);
        list.delete();

        // lru: hits on frames in the middle of the ring that relink it
        drain_and_set_mode(MODE_LRU);
        list.push_back(mk(2'd0, 24'h000123));
        list.push_back(mk(2'd1, 24'h555000));
        list.push_back(mk(2'd2, 24'h000777));
        send_burst(list);
        list.delete();

        // fill all frames so the next faults evict and clear old mappings
        drain_and_set_mode(MODE_FIFO);
        for (int i = 0; i < N_FRAMES + 4; i++) list.push_back(mk(2'(i), {12'(i + 100), 12'(i)}));
        list.push_back(mk(2'd0, 24'h000000));
        list.push_back(mk(2'd3, 24'hFFFFFF));
        send_burst(list);
        list.delete();

        // random phases across both modes, ending in lru
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_set_mode(ph[0] ? MODE_LRU : MODE_FIFO);
            for (int i = 0; i < N_RANDOM / 4; i++)
                list.push_back(rand_access(ph < 2 ? 120 : 400));
            recv_lru_hold = (ph == 3);
            send_burst(list);
            list.delete();
            recv_lru_hold = 1'b0;
        end

        while (xlate_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/slpt_pkg.sv
rtl/slpt_ring.sv
rtl/slpt_table.sv
rtl/single_level_page_translate.sv
tb/sv/tb_top.sv
